### sv/paged_memory_manager_unit_assert.svh
// Assertion macros used by the paged memory manager RTL.
`ifndef PAGED_MEMORY_MANAGER_UNIT_ASSERT_SVH
`define PAGED_MEMORY_MANAGER_UNIT_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define PMM_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define PMM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define PMM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

### sv/pmm_pkg.sv
package pmm_pkg;

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_WRITE = 2'd3;

  localparam logic [1:0]  REG_HEAP_START = 2'd0;
  localparam logic [16:0] HEAP_RESET     = 17'd1024;

  localparam int IN_W  = 56;
  localparam int OUT_W = 32;

  typedef logic [IN_W-1:0]  in_word_t;
  typedef logic [OUT_W-1:0] out_word_t;

endpackage

### sv/paged_memory_manager_unit.sv
// Paged memory manager.
// Input words (in_*) carry one operation each: alloc, free, read byte or
// write byte for one process. Every word yields exactly one result word
// (out_*) with status, start address of a new region and the byte read.
// The heap start register sits at byte address 0 of the APB port and may be
// written only while the block is idle.
// Words are taken one at a time: in_tready is high only when the block is
// idle. Each word is decoded, then a read or write looks up the map and
// accesses the RAM, an alloc scans the page table up to its last page and
// finishes, a free looks up the map, walks its page chain and unmaps it, and
// a failed or zero-size alloc goes straight to the result. The page table
// memory is read once a cycle during the alloc scan and the free walk, and
// the map memory is written once a cycle when pages are unmapped.
// After reset a clearing pass over all PAGE_COUNT << OFFSET_BITS RAM
// addresses (65536 by default) zeroes RAM, page table and map; no word is
// accepted during it, configuration writes are taken as usual.
// A finished result waits in an output register; while out_tready is low the
// block finishes at most one more word and then waits until the result leaves.
module paged_memory_manager_unit #(
  parameter int OFFSET_BITS = 10,
  parameter int PAGE_COUNT  = 64,
  parameter int PROC_COUNT  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // func[1:0], proc_id[3:2], address[23:4], alloc_size[43:24], write_data[51:44]
  input  pmm_pkg::in_word_t in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // status[0], start_addr[17:1], read_data[25:18]
  output pmm_pkg::out_word_t out_tdata,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [1:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import pmm_pkg::*;

  `include "paged_memory_manager_unit_assert.svh"

  localparam int PG_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int CNT_W     = $clog2(PAGE_COUNT + 1);
  localparam int PIX_W     = (PROC_COUNT > 1) ? $clog2(PROC_COUNT) : 1;
  localparam int MAP_DEPTH = PROC_COUNT * PAGE_COUNT;
  localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int RAM_DEPTH = PAGE_COUNT << OFFSET_BITS;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int PT_W      = PG_W + 2;
  localparam int MAP_W     = PG_W + 1;
  localparam int PGS_W     = 21 - OFFSET_BITS;
  localparam int VPU_W     = PG_W + 1;
  localparam int PAGE_BYTES = 1 << OFFSET_BITS;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DEC    = 4'd2;
  localparam logic [3:0] S_LCHK   = 4'd3;
  localparam logic [3:0] S_ASCAN  = 4'd4;
  localparam logic [3:0] S_AFIN   = 4'd5;
  localparam logic [3:0] S_FCHK   = 4'd6;
  localparam logic [3:0] S_FUNMAP = 4'd7;
  localparam logic [3:0] S_RDW    = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]        state_r, state_nxt;
  logic [RAM_AW-1:0] clr_r, clr_nxt;
  logic [16:0]       heap_r;
  logic [CNT_W-1:0]  free_cnt_r, free_cnt_nxt;
  logic [16:0]       brk_r [PROC_COUNT];
  logic [16:0]       brk_nxt [PROC_COUNT];
  logic              started_r [PROC_COUNT];
  logic              started_nxt [PROC_COUNT];

  logic [1:0]        func_r, func_nxt;
  logic [1:0]        pid_r, pid_nxt;
  logic [19:0]       addr_r, addr_nxt;
  logic [19:0]       size_r, size_nxt;
  logic [7:0]        wdata_r, wdata_nxt;
  logic [PGS_W-1:0]  pages_r, pages_nxt;
  logic [16:0]       bp_r, bp_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [PG_W-1:0]   chk_r, chk_nxt;
  logic [PG_W-1:0]   prev_r, prev_nxt;
  logic              have_prev_r, have_prev_nxt;
  logic [PG_W-1:0]   pg_r, pg_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [VPU_W-1:0]  vpu_r, vpu_nxt;
  logic              res_status_r, res_status_nxt;
  logic [16:0]       res_start_r, res_start_nxt;
  logic [7:0]        res_rdata_r, res_rdata_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_data_r, out_data_nxt;

  logic              pt_we;
  logic [PG_W-1:0]   pt_waddr, pt_raddr;
  logic [PT_W-1:0]   pt_wdata, pt_rdata;
  logic              map_we;
  logic [MAP_AW-1:0] map_waddr, map_raddr;
  logic [MAP_W-1:0]  map_wdata, map_rdata;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  logic [PIX_W-1:0]  pidx;
  logic              pid_ok;
  logic [16:0]       cur_brk;
  logic [PGS_W-1:0]  pages_calc;
  logic [31:0]       brk_sum;
  logic [31:0]       vp_in;
  logic [31:0]       pa_calc;
  logic              cfg_wr;

  pmm_ram #(.WIDTH(PT_W), .DEPTH(PAGE_COUNT)) u_page_ram (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  pmm_ram #(.WIDTH(MAP_W), .DEPTH(MAP_DEPTH)) u_map_ram (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  pmm_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_byte_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      ((cfg_paddr >> 2) == REG_HEAP_START);
  assign cfg_prdata = ((cfg_paddr >> 2) == REG_HEAP_START) ? {15'd0, heap_r} : 32'd0;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign pidx       = PIX_W'(pid_r);
  assign pid_ok     = (32'(pid_r) < PROC_COUNT);
  assign cur_brk    = started_r[pidx] ? brk_r[pidx] : heap_r;
  assign pages_calc = PGS_W'((21'(size_r) + 21'(PAGE_BYTES - 1)) >> OFFSET_BITS);
  assign brk_sum    = 32'(cur_brk) + (32'(pages_calc) << OFFSET_BITS);
  assign vp_in      = 32'(addr_r >> OFFSET_BITS);
  assign pa_calc    = (32'(map_rdata[PG_W-1:0]) << OFFSET_BITS) |
                      32'(addr_r[OFFSET_BITS-1:0]);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    free_cnt_nxt   = free_cnt_r;
    brk_nxt        = brk_r;
    started_nxt    = started_r;
    func_nxt       = func_r;
    pid_nxt        = pid_r;
    addr_nxt       = addr_r;
    size_nxt       = size_r;
    wdata_nxt      = wdata_r;
    pages_nxt      = pages_r;
    bp_nxt         = bp_r;
    k_nxt          = k_r;
    chk_nxt        = chk_r;
    prev_nxt       = prev_r;
    have_prev_nxt  = have_prev_r;
    pg_nxt         = pg_r;
    n_nxt          = n_r;
    i_nxt          = i_r;
    vpu_nxt        = vpu_r;
    res_status_nxt = res_status_r;
    res_start_nxt  = res_start_r;
    res_rdata_nxt  = res_rdata_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;

    pt_we     = 1'b0;
    pt_waddr  = '0;
    pt_wdata  = '0;
    pt_raddr  = '0;
    map_we    = 1'b0;
    map_waddr = '0;
    map_wdata = '0;
    map_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;

    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        if (32'(clr_r) < PAGE_COUNT) begin
          pt_we    = 1'b1;
          pt_waddr = PG_W'(clr_r);
        end
        if (32'(clr_r) < MAP_DEPTH) begin
          map_we    = 1'b1;
          map_waddr = MAP_AW'(clr_r);
        end
        clr_nxt = clr_r + 1'b1;
        if (clr_r == RAM_AW'(RAM_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt  = in_tdata[1:0];
          pid_nxt   = in_tdata[3:2];
          addr_nxt  = in_tdata[23:4];
          size_nxt  = in_tdata[43:24];
          wdata_nxt = in_tdata[51:44];
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        res_status_nxt = 1'b1;
        res_start_nxt  = '0;
        res_rdata_nxt  = '0;
        state_nxt      = S_DONE;
        if (pid_ok) begin
          if (func_r == FUNC_ALLOC) begin
            if (pages_calc == '0) begin
              res_status_nxt = 1'b0;
              res_start_nxt  = cur_brk;
            end else if (32'(free_cnt_r) >= 32'(pages_calc) &&
                         brk_sum <= 32'(RAM_DEPTH)) begin
              pages_nxt     = pages_calc;
              bp_nxt        = cur_brk;
              k_nxt         = '0;
              chk_nxt       = '0;
              have_prev_nxt = 1'b0;
              pt_raddr      = '0;
              state_nxt     = S_ASCAN;
            end
          end else if (vp_in < PAGE_COUNT) begin
            map_raddr = MAP_AW'(32'(pid_r) * PAGE_COUNT + vp_in);
            state_nxt = S_LCHK;
          end
        end
      end

      // The page table entry of chk_r is on pt_rdata; the next page is read meanwhile.
      S_ASCAN: begin
        pt_raddr = chk_r + 1'b1;
        chk_nxt  = chk_r + 1'b1;
        if (!pt_rdata[PT_W-1]) begin
          if (have_prev_r) begin
            pt_we    = 1'b1;
            pt_waddr = prev_r;
            pt_wdata = {1'b1, 1'b0, chk_r};
          end
          if (32'(bp_r >> OFFSET_BITS) + 32'(k_r) < PAGE_COUNT) begin
            map_we    = 1'b1;
            map_waddr = MAP_AW'(32'(pid_r) * PAGE_COUNT +
                                32'(bp_r >> OFFSET_BITS) + 32'(k_r));
            map_wdata = {1'b1, chk_r};
          end
          prev_nxt      = chk_r;
          have_prev_nxt = 1'b1;
          k_nxt         = k_r + 1'b1;
          if (32'(k_r) + 32'd1 == 32'(pages_r)) begin
            state_nxt = S_AFIN;
          end
        end
      end

      S_AFIN: begin
        pt_we              = 1'b1;
        pt_waddr           = prev_r;
        pt_wdata           = {1'b1, 1'b1, PG_W'(0)};
        free_cnt_nxt       = CNT_W'(32'(free_cnt_r) - 32'(pages_r));
        brk_nxt[pidx]      = 17'(32'(bp_r) + (32'(pages_r) << OFFSET_BITS));
        started_nxt[pidx]  = 1'b1;
        res_status_nxt     = 1'b0;
        res_start_nxt      = bp_r;
        state_nxt          = S_DONE;
      end

      S_LCHK: begin
        if (!map_rdata[MAP_W-1]) begin
          state_nxt = S_DONE;
        end else begin
          case (func_r)
            FUNC_FREE: begin
              pt_raddr  = map_rdata[PG_W-1:0];
              pg_nxt    = map_rdata[PG_W-1:0];
              n_nxt     = '0;
              state_nxt = S_FCHK;
            end
            FUNC_READ: begin
              ram_raddr = RAM_AW'(pa_calc);
              state_nxt = S_RDW;
            end
            default: begin
              ram_we         = 1'b1;
              ram_waddr      = RAM_AW'(pa_calc);
              ram_wdata      = wdata_r;
              res_status_nxt = 1'b0;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end

      // Chain links always point to a higher page, so the page written here
      // is never the one read for the next step.
      S_FCHK: begin
        pt_we    = 1'b1;
        pt_waddr = pg_r;
        pt_wdata = {1'b0, pt_rdata[PT_W-2:0]};
        if (pt_rdata[PT_W-1]) begin
          free_cnt_nxt = free_cnt_r + 1'b1;
        end
        n_nxt    = n_r + 1'b1;
        pt_raddr = pt_rdata[PG_W-1:0];
        pg_nxt   = pt_rdata[PG_W-1:0];
        if (pt_rdata[PT_W-2] || (32'(n_r) + 32'd1 == PAGE_COUNT) ||
            (32'(pt_rdata[PG_W-1:0]) >= PAGE_COUNT)) begin
          i_nxt     = '0;
          vpu_nxt   = VPU_W'(vp_in);
          state_nxt = S_FUNMAP;
        end
      end

      S_FUNMAP: begin
        if (i_r == n_r || 32'(vpu_r) == PAGE_COUNT) begin
          if (32'(addr_r) + (32'(n_r) << OFFSET_BITS) == 32'(cur_brk)) begin
            brk_nxt[pidx]     = addr_r[16:0];
            started_nxt[pidx] = 1'b1;
          end
          res_status_nxt = 1'b0;
          state_nxt      = S_DONE;
        end else begin
          map_we    = 1'b1;
          map_waddr = MAP_AW'(32'(pid_r) * PAGE_COUNT + 32'(vpu_r));
          i_nxt     = i_r + 1'b1;
          vpu_nxt   = vpu_r + 1'b1;
        end
      end

      S_RDW: begin
        res_status_nxt = 1'b0;
        res_rdata_nxt  = ram_rdata;
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, res_rdata_r, res_start_r, res_status_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      heap_r      <= HEAP_RESET;
      free_cnt_r  <= CNT_W'(PAGE_COUNT);
      out_valid_r <= 1'b0;
      for (int p = 0; p < PROC_COUNT; p++) begin
        brk_r[p]     <= '0;
        started_r[p] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_cnt_r  <= free_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      brk_r       <= brk_nxt;
      started_r   <= started_nxt;
      if (cfg_wr) begin
        heap_r <= cfg_pwdata[16:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    pid_r        <= pid_nxt;
    addr_r       <= addr_nxt;
    size_r       <= size_nxt;
    wdata_r      <= wdata_nxt;
    pages_r      <= pages_nxt;
    bp_r         <= bp_nxt;
    k_r          <= k_nxt;
    chk_r        <= chk_nxt;
    prev_r       <= prev_nxt;
    have_prev_r  <= have_prev_nxt;
    pg_r         <= pg_nxt;
    n_r          <= n_nxt;
    i_r          <= i_nxt;
    vpu_r        <= vpu_nxt;
    res_status_r <= res_status_nxt;
    res_start_r  <= res_start_nxt;
    res_rdata_r  <= res_rdata_nxt;
    out_data_r   <= out_data_nxt;
  end

  `PMM_ASSERT_ALWAYS(a_free_cnt_range, 32'(free_cnt_r) <= PAGE_COUNT)
  `PMM_ASSERT_NEXT(a_accept_leaves_idle, in_tvalid && in_tready, state_r == S_DEC)
  `PMM_ASSERT_IMPL(a_result_from_done, $rose(out_valid_r), $past(state_r == S_DONE))
  `PMM_ASSERT_IMPL(a_no_accept_in_clear, state_r == S_CLR, !in_tready)

endmodule

### sv/pmm_ram.sv
module pmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
